@@ rtl/core/udwm_pkg.sv @@
package udwm_pkg;

  localparam int unsigned CpW = 21;

  typedef logic [CpW-1:0] cp_t;

  // One decoded input byte: a run of invalid units, an optional unit (valid or
  // invalid) at position pre, then a run of flushed invalid units.
  typedef struct packed {
    logic [2:0] pre;
    logic [2:0] n;
    logic       has_spec;
    logic       spec_valid;
    cp_t        spec_cp;
    logic [2:0] spec_len;
    logic [1:0] spec_width;
    logic       is_end;
  } job_t;

  localparam cp_t MaxCp      = 21'h10FFFF;
  localparam cp_t SurrLo     = 21'h00D800;
  localparam cp_t SurrHi     = 21'h00DFFF;
  localparam cp_t MinCp2     = 21'h000080;
  localparam cp_t MinCp3     = 21'h000800;
  localparam cp_t MinCp4     = 21'h010000;
  localparam cp_t CtrlEnd    = 21'h000020;
  localparam cp_t DelCp      = 21'h00007F;
  localparam cp_t C1End      = 21'h0000A0;

  localparam logic [15:0] MaxColumnsReset = 16'd80;

  localparam int unsigned NumZero = 8;
  localparam int unsigned NumWide = 14;

  localparam cp_t ZeroLo [NumZero] = '{
    21'h0300, 21'h0483, 21'h0591, 21'h0610,
    21'h064B, 21'h200B, 21'h20D0, 21'hFE00
  };
  localparam cp_t ZeroHi [NumZero] = '{
    21'h036F, 21'h0489, 21'h05BD, 21'h061A,
    21'h065F, 21'h200F, 21'h20F0, 21'hFE0F
  };
  localparam cp_t WideLo [NumWide] = '{
    21'h1100, 21'h2E80, 21'h3041, 21'h3400, 21'h4E00, 21'hA000, 21'hAC00,
    21'hF900, 21'hFE10, 21'hFE30, 21'hFF00, 21'hFFE0, 21'h1F300, 21'h20000
  };
  localparam cp_t WideHi [NumWide] = '{
    21'h115F, 21'h303E, 21'h33FF, 21'h4DBF, 21'h9FFF, 21'hA4CF, 21'hD7A3,
    21'hFAFF, 21'hFE19, 21'hFE6F, 21'hFF60, 21'hFFE6, 21'h1F9FF, 21'h3FFFD
  };

  // Terminal column width of a well-formed code point.
  function automatic logic [1:0] cp_width(cp_t cp);
    logic is_zero;
    logic is_wide;
    is_zero = (cp < CtrlEnd) || (cp >= DelCp && cp < C1End);
    is_wide = 1'b0;
    for (int i = 0; i < NumZero; i++) begin
      if (cp >= ZeroLo[i] && cp <= ZeroHi[i]) is_zero = 1'b1;
    end
    for (int i = 0; i < NumWide; i++) begin
      if (cp >= WideLo[i] && cp <= WideHi[i]) is_wide = 1'b1;
    end
    if (is_zero) return 2'd0;
    if (is_wide) return 2'd2;
    return 2'd1;
  endfunction

endpackage

@@ rtl/core/utf8_display_width_meter_core.sv @@
// An accepted byte is held in the job register; its units leave by the output register.
// Throughput: one byte per cycle while the output is not stalled and each byte yields
// at most one unit; a byte with several units (broken, rejected or flushed sequences,
// up to four) holds input while the single result register emits one unit per cycle.
// Reset: asynchronous, active low; clears decode state, counters and valid flags and
// loads max_columns with 80.
module utf8_display_width_meter_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,       // max_columns
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,      // data_byte
  input  logic        s_axis_tlast,      // string_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [20:0] code_point, [21] valid_res, [24:22] byte_count, [26:25] glyph_width,
  // [42:27] total_columns, [58:43] kept_bytes, [74:59] kept_columns, rest zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,      // end_of_string
  output logic        m_axis_tuser       // last_in_run
);

  localparam int unsigned CmpW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [CmpW-1:0] CntMaxC = CmpW'({COUNT_BITS{1'b1}});

  // Configuration
  logic [15:0] max_q;

  // Decode state
  logic [2:0]          exp_q, exp_d;
  logic [1:0]          pend_q, pend_d;
  udwm_pkg::cp_t       acc_q, acc_d;

  // Job register
  udwm_pkg::job_t      job_q, job_d;
  logic                job_valid_q;
  logic [1:0]          idx_q;

  // Counters
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [COUNT_BITS-1:0] pcol_q, pcol_d;
  logic [COUNT_BITS-1:0] pbyt_q, pbyt_d;
  logic                  closed_q, closed_d;

  // Output register
  logic                out_valid_q;
  udwm_pkg::cp_t       o_cp_q;
  logic                o_valid_q;
  logic [2:0]          o_len_q;
  logic [1:0]          o_w_q;
  logic [15:0]         o_total_q, o_kb_q, o_kc_q;
  logic                o_end_q, o_last_q;

  logic s_accept, out_load, emit, unit_last;

  // ---------------- Decode of the incoming byte ----------------
  logic [7:0]    b;
  logic [2:0]    got;
  udwm_pkg::cp_t acc_n;
  logic          cp_bad;
  logic          fresh;
  logic [1:0]    post;

  always_comb begin
    b      = s_axis_tdata;
    got    = {1'b0, pend_q} + 3'd1;
    acc_n  = {acc_q[udwm_pkg::CpW-7:0], b[5:0]};
    cp_bad = (exp_q == 3'd2 && acc_n < udwm_pkg::MinCp2) ||
             (exp_q == 3'd3 && acc_n < udwm_pkg::MinCp3) ||
             (exp_q == 3'd4 && acc_n < udwm_pkg::MinCp4) ||
             (acc_n >= udwm_pkg::SurrLo && acc_n <= udwm_pkg::SurrHi) ||
             (acc_n > udwm_pkg::MaxCp);
    exp_d  = exp_q;
    pend_d = pend_q;
    acc_d  = acc_q;
    fresh  = 1'b1;
    post   = 2'd0;
    job_d  = '0;
    job_d.is_end   = s_axis_tlast;
    job_d.spec_len = 3'd1;

    if (exp_q != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 1'b0;
        if (got >= exp_q) begin
          if (cp_bad) begin
            job_d.pre = got;
          end else begin
            job_d.has_spec   = 1'b1;
            job_d.spec_valid = 1'b1;
            job_d.spec_cp    = acc_n;
            job_d.spec_len   = exp_q;
          end
          exp_d  = 3'd0;
          pend_d = 2'd0;
          acc_d  = '0;
        end else begin
          pend_d = got[1:0];
          acc_d  = acc_n;
        end
      end else begin
        // A non-continuation byte breaks the sequence; the pending bytes
        // become invalid units and the byte is decoded afresh.
        job_d.pre = {1'b0, pend_q};
        exp_d  = 3'd0;
        pend_d = 2'd0;
        acc_d  = '0;
      end
    end

    if (fresh) begin
      priority if (b[7] == 1'b0) begin
        job_d.has_spec   = 1'b1;
        job_d.spec_valid = 1'b1;
        job_d.spec_cp    = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        exp_d  = 3'd2;
        pend_d = 2'd1;
        acc_d  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        exp_d  = 3'd3;
        pend_d = 2'd1;
        acc_d  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        exp_d  = 3'd4;
        pend_d = 2'd1;
        acc_d  = {18'd0, b[2:0]};
      end else begin
        job_d.has_spec = 1'b1;
      end
    end

    // The end of the string flushes whatever is still pending.
    if (s_axis_tlast && exp_d != 3'd0) begin
      post   = pend_d;
      exp_d  = 3'd0;
      pend_d = 2'd0;
      acc_d  = '0;
    end

    job_d.n = job_d.pre + {2'd0, job_d.has_spec} + {1'b0, post};
    job_d.spec_width = job_d.spec_valid ? udwm_pkg::cp_width(job_d.spec_cp) : 2'd1;
  end

  // ---------------- Unit emission ----------------
  logic                is_spec;
  udwm_pkg::cp_t       u_cp;
  logic                u_valid;
  logic [2:0]          u_len;
  logic [1:0]          u_w;
  logic [COUNT_BITS:0] total_sum;
  logic [CmpW-1:0]     pcol_sum, pbyt_sum, max_c;
  logic                fits;
  logic [CmpW-1:0]     total_x, pcol_x, pbyt_x;

  always_comb begin
    is_spec   = job_q.has_spec && ({1'b0, idx_q} == job_q.pre);
    unit_last = ({1'b0, idx_q} == (job_q.n - 3'd1));
    u_cp      = is_spec ? job_q.spec_cp : '0;
    u_valid   = is_spec && job_q.spec_valid;
    u_len     = is_spec ? job_q.spec_len : 3'd1;
    u_w       = is_spec ? job_q.spec_width : 2'd1;

    total_sum = {1'b0, total_q} + (COUNT_BITS+1)'(u_w);
    total_d   = total_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total_sum[COUNT_BITS-1:0];

    pcol_sum = CmpW'(pcol_q) + CmpW'(u_w);
    pbyt_sum = CmpW'(pbyt_q) + CmpW'(u_len);
    max_c    = CmpW'(max_q);
    fits     = (pcol_sum <= max_c);

    closed_d = closed_q || (max_q == 16'd0);
    pcol_d   = pcol_q;
    pbyt_d   = pbyt_q;
    if (!closed_d) begin
      if (!fits) begin
        closed_d = 1'b1;
      end else begin
        pcol_d = (pcol_sum > CntMaxC) ? {COUNT_BITS{1'b1}} : pcol_sum[COUNT_BITS-1:0];
        pbyt_d = (pbyt_sum > CntMaxC) ? {COUNT_BITS{1'b1}} : pbyt_sum[COUNT_BITS-1:0];
      end
    end

    total_x = CmpW'(total_d);
    pcol_x  = CmpW'(pcol_d);
    pbyt_x  = CmpW'(pbyt_d);
  end

  assign out_load      = !out_valid_q || m_axis_tready;
  assign emit          = job_valid_q && out_load;
  assign s_axis_tready = !job_valid_q || (emit && unit_last);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= udwm_pkg::MaxColumnsReset;
      exp_q       <= '0;
      pend_q      <= '0;
      acc_q       <= '0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      total_q     <= '0;
      pcol_q      <= '0;
      pbyt_q      <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (s_accept) begin
        exp_q       <= exp_d;
        pend_q      <= pend_d;
        acc_q       <= acc_d;
        job_valid_q <= (job_d.n != 3'd0);
      end else if (emit && unit_last) begin
        job_valid_q <= 1'b0;
      end
      if (emit) begin
        idx_q <= unit_last ? 2'd0 : idx_q + 2'd1;
        if (unit_last && job_q.is_end) begin
          total_q  <= '0;
          pcol_q   <= '0;
          pbyt_q   <= '0;
          closed_q <= 1'b0;
        end else begin
          total_q  <= total_d;
          pcol_q   <= pcol_d;
          pbyt_q   <= pbyt_d;
          closed_q <= closed_d;
        end
      end
      if (out_load) begin
        out_valid_q <= job_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      job_q <= job_d;
    end
    if (emit) begin
      o_cp_q    <= u_cp;
      o_valid_q <= u_valid;
      o_len_q   <= u_len;
      o_w_q     <= u_w;
      o_total_q <= total_x[15:0];
      o_kb_q    <= pbyt_x[15:0];
      o_kc_q    <= pcol_x[15:0];
      o_end_q   <= unit_last && job_q.is_end;
      o_last_q  <= unit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, o_kc_q, o_kb_q, o_total_q, o_w_q, o_len_q, o_valid_q, o_cp_q};
  assign m_axis_tlast  = o_end_q;
  assign m_axis_tuser  = o_last_q;

  // ---------------- Assertions ----------------
  a_job_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.n != 3'd0 && job_q.n <= 3'd4))
    else $error("job register holds an impossible unit count");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 3'd0) |-> (pend_q != 2'd0 && {1'b0, pend_q} < exp_q))
    else $error("pending byte count out of range for the open sequence");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("end of string not on the last unit of a byte");

  a_invalid_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[21]) |->
      (m_axis_tdata[20:0] == '0 && m_axis_tdata[24:22] == 3'd1 &&
       m_axis_tdata[26:25] == 2'd1))
    else $error("invalid unit with nonstandard fields");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && unit_last && job_q.is_end) |=> (total_q == '0 && !closed_q))
    else $error("counters not cleared at end of string");

endmodule
